FILE: hdl/i2cdl_pkg.sv
// ----------------------------------------------------------------------------
// i2cdl_pkg
// Shared types and constants for the write-only display I2C link.
// ----------------------------------------------------------------------------
package i2cdl_pkg;

  // Configuration register indexes
  localparam logic CFG_DEVICE_ADDRESS = 1'b0;
  localparam logic CFG_PHASE_TICKS    = 1'b1;

  localparam int unsigned CFG_INDEX_W = 1;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [7:0]  DEVICE_ADDRESS_RST = 8'd120;
  localparam logic [15:0] PHASE_TICKS_RST    = 16'd1;

  // Control byte that precedes the payload
  localparam logic [7:0] CTRL_CMD  = 8'h00;
  localparam logic [7:0] CTRL_DATA = 8'h40;

  // Input action codes
  localparam logic ACT_TICK = 1'b0;
  localparam logic ACT_SEND = 1'b1;

  // Byte slots within a frame
  localparam logic [1:0] SLOT_ADDR = 2'd0;
  localparam logic [1:0] SLOT_CTRL = 2'd1;
  localparam logic [1:0] SLOT_LAST = 2'd3;

  // Sub-phase index used within START and STOP
  localparam logic [3:0] SUB_FIRST  = 4'd0;
  localparam logic [3:0] SUB_SECOND = 4'd1;
  localparam logic [3:0] SUB_THIRD  = 4'd2;
  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  typedef enum logic [2:0] {
    ST_IDLE     = 3'd0,
    ST_START    = 3'd1,
    ST_BIT_LOW  = 3'd2,
    ST_BIT_HIGH = 3'd3,
    ST_ACK_LOW  = 3'd4,
    ST_ACK_HIGH = 3'd5,
    ST_STOP     = 3'd6
  } step_e;

  typedef struct packed {
    logic       action;
    logic       is_data;
    logic [7:0] payload;
  } in_beat_t;

  typedef struct packed {
    logic scl;
    logic sda;
    logic busy_res;
    logic rejected;
    logic frame_done;
  } out_beat_t;

endpackage

FILE: hdl/i2c_write_only_display_link.sv
// ----------------------------------------------------------------------------
// i2c_write_only_display_link
// Write-only I2C master that sends a command or data byte to a display.
// ----------------------------------------------------------------------------
// Every input beat, tick or send request, yields exactly one result beat that
// shows the SCL/SDA levels after that beat, the busy flag, a reject flag for a
// request made mid-frame and a done pulse on the tick that ends STOP. The block
// takes one beat per clock cycle unless stalled; the result is loaded into the
// output register on acceptance, and input stall rises only while that register
// holds a result that the far side stalls. A frame is START, the device address,
// the control byte (0x00 command, 0x40 data), the payload and STOP, each byte
// followed by an unsampled ack pulse; every pin phase lasts phase_ticks ticks
// (zero counts as one). Write configuration only while no frame is running.
module i2c_write_only_display_link (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  i2cdl_pkg::in_beat_t                    in_data_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output i2cdl_pkg::out_beat_t                   out_data_o,
  input  logic                                   cfg_we_i,
  input  logic [i2cdl_pkg::CFG_INDEX_W-1:0]      cfg_index_i,
  input  logic [i2cdl_pkg::CFG_DATA_W-1:0]       cfg_data_i
);

  logic [7:0]  dev_addr_q;
  logic [15:0] phase_q;

  i2cdl_pkg::step_e step_q, step_d;
  logic [1:0]  byte_slot_q, byte_slot_d;
  logic [3:0]  bit_slot_q, bit_slot_d;
  logic [7:0]  shift_q, shift_d;
  logic [7:0]  payload_q, payload_d;
  logic        kind_q, kind_d;
  logic [15:0] hold_q, hold_d;
  logic        scl_q, scl_d;
  logic        sda_q, sda_d;

  i2cdl_pkg::out_beat_t out_q, out_d;
  logic                 out_valid_q;

  logic        accept;
  logic        busy;
  logic        rej;
  logic        done;
  logic [15:0] phase_len;
  logic [15:0] hold_dec;
  logic [7:0]  load_val;
  logic [7:0]  shift_nxt;
  logic [3:0]  bit_inc;
  logic [1:0]  byte_inc;

  assign in_stall_o  = out_valid_q & out_stall_i;
  assign accept      = in_valid_i & ~in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign busy      = (step_q != i2cdl_pkg::ST_IDLE);
  assign phase_len = (phase_q == '0) ? 16'd1 : phase_q;
  assign hold_dec  = (hold_q != '0) ? hold_q - 16'd1 : '0;
  assign shift_nxt = {shift_q[6:0], 1'b0};
  assign bit_inc   = bit_slot_q + 4'd1;
  assign byte_inc  = byte_slot_q + 2'd1;

  // Byte to load when the next byte begins; the slot is the one being entered
  always_comb begin
    case (step_q)
      i2cdl_pkg::ST_ACK_HIGH: begin
        load_val = (byte_inc == i2cdl_pkg::SLOT_CTRL)
                 ? (kind_q ? i2cdl_pkg::CTRL_DATA : i2cdl_pkg::CTRL_CMD)
                 : payload_q;
      end
      default: begin
        load_val = dev_addr_q;
      end
    endcase
  end

  // Next state
  always_comb begin
    step_d      = step_q;
    byte_slot_d = byte_slot_q;
    bit_slot_d  = bit_slot_q;
    shift_d     = shift_q;
    payload_d   = payload_q;
    kind_d      = kind_q;
    hold_d      = hold_q;
    scl_d       = scl_q;
    sda_d       = sda_q;
    rej         = 1'b0;
    done        = 1'b0;

    if (in_data_i.action == i2cdl_pkg::ACT_SEND) begin
      if (busy) begin
        rej = 1'b1;
      end else begin
        payload_d   = in_data_i.payload;
        kind_d      = in_data_i.is_data;
        byte_slot_d = '0;
        bit_slot_d  = '0;
        shift_d     = '0;
        step_d      = i2cdl_pkg::ST_START;
        scl_d       = 1'b1;
        sda_d       = 1'b1;
        hold_d      = phase_len;
      end
    end else if (busy) begin
      hold_d = hold_dec;
      if (hold_dec == '0) begin
        // Phase over: advance the pin sequence
        hold_d = phase_len;
        case (step_q)
          i2cdl_pkg::ST_START: begin
            if (bit_slot_q == i2cdl_pkg::SUB_FIRST) begin
              bit_slot_d = i2cdl_pkg::SUB_SECOND;
              scl_d      = 1'b1;
              sda_d      = 1'b0;
            end else if (bit_slot_q == i2cdl_pkg::SUB_SECOND) begin
              bit_slot_d = i2cdl_pkg::SUB_THIRD;
              scl_d      = 1'b0;
              sda_d      = 1'b0;
            end else begin
              byte_slot_d = i2cdl_pkg::SLOT_ADDR;
              shift_d     = load_val;
              bit_slot_d  = '0;
              step_d      = i2cdl_pkg::ST_BIT_LOW;
              scl_d       = 1'b0;
              sda_d       = load_val[7];
            end
          end
          i2cdl_pkg::ST_BIT_LOW: begin
            step_d = i2cdl_pkg::ST_BIT_HIGH;
            scl_d  = 1'b1;
            sda_d  = shift_q[7];
          end
          i2cdl_pkg::ST_BIT_HIGH: begin
            shift_d    = shift_nxt;
            bit_slot_d = bit_inc;
            scl_d      = 1'b0;
            if (bit_inc >= i2cdl_pkg::BITS_PER_BYTE) begin
              step_d = i2cdl_pkg::ST_ACK_LOW;
              sda_d  = 1'b1;
            end else begin
              step_d = i2cdl_pkg::ST_BIT_LOW;
              sda_d  = shift_nxt[7];
            end
          end
          i2cdl_pkg::ST_ACK_LOW: begin
            step_d = i2cdl_pkg::ST_ACK_HIGH;
            scl_d  = 1'b1;
            sda_d  = 1'b1;
          end
          i2cdl_pkg::ST_ACK_HIGH: begin
            byte_slot_d = byte_inc;
            bit_slot_d  = '0;
            scl_d       = 1'b0;
            if (byte_inc == i2cdl_pkg::SLOT_LAST || byte_inc == i2cdl_pkg::SLOT_ADDR) begin
              step_d = i2cdl_pkg::ST_STOP;
              sda_d  = 1'b0;
            end else begin
              shift_d = load_val;
              step_d  = i2cdl_pkg::ST_BIT_LOW;
              sda_d   = load_val[7];
            end
          end
          i2cdl_pkg::ST_STOP: begin
            if (bit_slot_q == i2cdl_pkg::SUB_FIRST) begin
              bit_slot_d = i2cdl_pkg::SUB_SECOND;
              scl_d      = 1'b1;
              sda_d      = 1'b0;
            end else if (bit_slot_q == i2cdl_pkg::SUB_SECOND) begin
              bit_slot_d = i2cdl_pkg::SUB_THIRD;
              scl_d      = 1'b1;
              sda_d      = 1'b1;
            end else begin
              step_d      = i2cdl_pkg::ST_IDLE;
              scl_d       = 1'b1;
              sda_d       = 1'b1;
              hold_d      = '0;
              bit_slot_d  = '0;
              byte_slot_d = '0;
              done        = 1'b1;
            end
          end
          default: begin
            step_d = i2cdl_pkg::ST_IDLE;
            scl_d  = 1'b1;
            sda_d  = 1'b1;
            hold_d = '0;
          end
        endcase
      end
    end
  end

  // Result fields
  always_comb begin
    out_d.scl        = scl_d;
    out_d.sda        = sda_d;
    out_d.busy_res   = (step_d != i2cdl_pkg::ST_IDLE);
    out_d.rejected   = rej;
    out_d.frame_done = done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q <= i2cdl_pkg::DEVICE_ADDRESS_RST;
      phase_q    <= i2cdl_pkg::PHASE_TICKS_RST;
    end else if (cfg_we_i) begin
      if (cfg_index_i == i2cdl_pkg::CFG_DEVICE_ADDRESS) begin
        dev_addr_q <= cfg_data_i[7:0];
      end else begin
        phase_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= i2cdl_pkg::ST_IDLE;
      byte_slot_q <= '0;
      bit_slot_q  <= '0;
      shift_q     <= '0;
      payload_q   <= '0;
      kind_q      <= 1'b0;
      hold_q      <= '0;
      scl_q       <= 1'b1;
      sda_q       <= 1'b1;
    end else if (accept) begin
      step_q      <= step_d;
      byte_slot_q <= byte_slot_d;
      bit_slot_q  <= bit_slot_d;
      shift_q     <= shift_d;
      payload_q   <= payload_d;
      kind_q      <= kind_d;
      hold_q      <= hold_d;
      scl_q       <= scl_d;
      sda_q       <= sda_d;
    end
  end

  // Result register: load on accept, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= out_d;
    end
  end

endmodule

FILE: hdl/i2cdl_checker.sv
// ----------------------------------------------------------------------------
// i2cdl_checker
// Port-level checks for the write-only display I2C link.
// ----------------------------------------------------------------------------
module i2cdl_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input i2cdl_pkg::out_beat_t out_data_o
);

  // Every accepted beat shows up as a result in the next cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o)
    else $error("accepted beat produced no result");

  // Stall only while a result is waiting
  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a pending result");

  // Lines float high whenever no frame is running
  a_idle_lines: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.busy_res |-> out_data_o.scl && out_data_o.sda)
    else $error("lines not released while idle");

  // The done beat ends the frame
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.frame_done |-> !out_data_o.busy_res
      && !out_data_o.rejected)
    else $error("frame_done with busy or rejected set");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

endmodule

bind i2c_write_only_display_link i2cdl_checker u_i2cdl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

FILE: test/display_frame_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// display_frame_pkg
// Expected pin levels for the write-only display I2C link. Each accepted beat
// steps a local copy of the frame sequencer; result beats are checked in order.
// ----------------------------------------------------------------------------
package display_frame_pkg;
  import i2cdl_pkg::*;

  class frame_predictor;
    logic [7:0]  dev_addr;
    logic [15:0] phase_len;
    step_e       step;
    logic [1:0]  byte_idx;
    logic [3:0]  bit_idx;
    logic [7:0]  shifter;
    logic [7:0]  pay_hold;
    logic        kind_hold;
    logic [15:0] hold_left;
    logic        scl;
    logic        sda;
    out_beat_t   expected_levels[$];
    int          fail_count;

    function new();
      dev_addr   = DEVICE_ADDRESS_RST;
      phase_len  = PHASE_TICKS_RST;
      step       = ST_IDLE;
      byte_idx   = SLOT_ADDR;
      bit_idx    = SUB_FIRST;
      shifter    = '0;
      pay_hold   = '0;
      kind_hold  = 1'b0;
      hold_left  = '0;
      scl        = 1'b1;
      sda        = 1'b1;
      fail_count = 0;
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      if (idx == CFG_DEVICE_ADDRESS) dev_addr = value[7:0];
      else if (idx == CFG_PHASE_TICKS) phase_len = value;
    endfunction

    function bit busy();
      return step != ST_IDLE;
    endfunction

    function int pending();
      return expected_levels.size();
    endfunction

    // Zero length phases count as one tick.
    function void set_pins(step_e s, logic c, logic d);
      step      = s;
      scl       = c;
      sda       = d;
      hold_left = (phase_len == '0) ? 16'd1 : phase_len;
    endfunction

    function void load_byte();
      case (byte_idx)
        SLOT_ADDR: shifter = dev_addr;
        SLOT_CTRL: shifter = kind_hold ? CTRL_DATA : CTRL_CMD;
        default:   shifter = pay_hold;
      endcase
      bit_idx = SUB_FIRST;
      set_pins(ST_BIT_LOW, 1'b0, shifter[7]);
    endfunction

    // Move to the next phase; return 1 when STOP has just finished.
    function bit advance();
      case (step)
        ST_START: begin
          if (bit_idx == SUB_FIRST) begin
            bit_idx = SUB_SECOND;
            set_pins(ST_START, 1'b1, 1'b0);
          end else if (bit_idx == SUB_SECOND) begin
            bit_idx = SUB_THIRD;
            set_pins(ST_START, 1'b0, 1'b0);
          end else begin
            byte_idx = SLOT_ADDR;
            load_byte();
          end
        end
        ST_BIT_LOW: set_pins(ST_BIT_HIGH, 1'b1, shifter[7]);
        ST_BIT_HIGH: begin
          shifter = shifter << 1;
          bit_idx = bit_idx + 4'd1;
          if (bit_idx >= BITS_PER_BYTE) set_pins(ST_ACK_LOW, 1'b0, 1'b1);
          else set_pins(ST_BIT_LOW, 1'b0, shifter[7]);
        end
        ST_ACK_LOW: set_pins(ST_ACK_HIGH, 1'b1, 1'b1);
        ST_ACK_HIGH: begin
          byte_idx = byte_idx + 2'd1;
          if (byte_idx == SLOT_LAST || byte_idx == SLOT_ADDR) begin
            bit_idx = SUB_FIRST;
            set_pins(ST_STOP, 1'b0, 1'b0);
          end else begin
            load_byte();
          end
        end
        ST_STOP: begin
          if (bit_idx == SUB_FIRST) begin
            bit_idx = SUB_SECOND;
            set_pins(ST_STOP, 1'b1, 1'b0);
          end else if (bit_idx == SUB_SECOND) begin
            bit_idx = SUB_THIRD;
            set_pins(ST_STOP, 1'b1, 1'b1);
          end else begin
            step      = ST_IDLE;
            scl       = 1'b1;
            sda       = 1'b1;
            hold_left = '0;
            bit_idx   = SUB_FIRST;
            byte_idx  = SLOT_ADDR;
            return 1'b1;
          end
        end
        default: begin
          step      = ST_IDLE;
          scl       = 1'b1;
          sda       = 1'b1;
          hold_left = '0;
        end
      endcase
      return 1'b0;
    endfunction

    function void note_beat(in_beat_t b);
      out_beat_t r;
      bit        was_busy;
      r        = '0;
      was_busy = busy();
      if (b.action == ACT_SEND) begin
        if (was_busy) begin
          r.rejected = 1'b1;
        end else begin
          pay_hold  = b.payload;
          kind_hold = b.is_data;
          byte_idx  = SLOT_ADDR;
          bit_idx   = SUB_FIRST;
          shifter   = '0;
          set_pins(ST_START, 1'b1, 1'b1);
        end
      end else if (was_busy) begin
        if (hold_left != '0) hold_left = hold_left - 16'd1;
        if (hold_left == '0 && advance()) r.frame_done = 1'b1;
      end
      r.scl      = scl;
      r.sda      = sda;
      r.busy_res = busy();
      expected_levels.push_back(r);
    endfunction

    // Fields print as scl, sda, busy, rejected, done.
    function void flag_error(string what, out_beat_t want, out_beat_t got);
      fail_count++;
      if (fail_count <= 10)
        $display("%0t: %s: expected %b%b%b%b%b, got %b%b%b%b%b",
                 $realtime, what, want.scl, want.sda, want.busy_res, want.rejected,
                 want.frame_done, got.scl, got.sda, got.busy_res, got.rejected,
                 got.frame_done);
    endfunction

    function void check_beat(out_beat_t got);
      out_beat_t want;
      if (expected_levels.size() == 0) begin
        flag_error("result beat with nothing outstanding", '0, got);
        return;
      end
      want = expected_levels.pop_front();
      if (got.scl !== want.scl || got.sda !== want.sda || got.busy_res !== want.busy_res ||
          got.rejected !== want.rejected || got.frame_done !== want.frame_done)
        flag_error("pin level mismatch", want, got);
    endfunction
  endclass

endpackage

FILE: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives ticks and send requests into the display I2C link under random
// sender gaps and receiver stalls, with register changes between phases, and
// checks every result beat against a cycle-free model of the frame sequencer.
// ----------------------------------------------------------------------------
module testbench;
  import i2cdl_pkg::*;
  import display_frame_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int TAIL_CYCLES = 20;

  logic                   clk_i;
  logic                   rst_ni    = 1'b0;
  logic                   in_valid  = 1'b0;
  logic                   in_stall;
  in_beat_t               in_data   = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  out_beat_t              out_data;
  logic                   cfg_we    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = CFG_DEVICE_ADDRESS;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  frame_predictor frames = new();
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int quiet_cycles  = 0;

  i2c_write_only_display_link u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Check result beats, toggle the receiver stall and watch for a hang.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid === 1'b1 && !out_stall) frames.check_beat(out_data);
      if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      out_stall <= ($urandom_range(99) < stall_pct);
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("i2c_write_only_display_link regression: fail");
        $finish;
      end
    end
  end

  function automatic in_beat_t make_beat(logic act, logic kind, logic [7:0] pay);
    in_beat_t b;
    b.action  = act;
    b.is_data = kind;
    b.payload = pay;
    return b;
  endfunction

  // Hold the beat until it is taken; gaps go in front of it.
  task automatic send_beat(input in_beat_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk_i); while (in_stall !== 1'b0);
    frames.note_beat(b);
  endtask

  // Mostly well-formed traffic: start a frame when idle, tick it along when
  // busy, with the odd request landing mid-frame.
  task automatic random_beat();
    int  pick;
    logic act;
    pick = $urandom_range(99);
    if (!frames.busy()) act = (pick < 80) ? ACT_SEND : ACT_TICK;
    else act = (pick < 5) ? ACT_SEND : ACT_TICK;
    send_beat(make_beat(act, 1'($urandom_range(1)), 8'($urandom_range(255))));
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (frames.pending() != 0) @(posedge clk_i);
  endtask

  // Tick the current frame through STOP, then wait for its results.
  task automatic settle();
    while (frames.busy())
      send_beat(make_beat(ACT_TICK, 1'($urandom_range(1)), 8'($urandom_range(255))));
    drain_results();
  endtask

  task automatic write_regs(input logic [7:0] addr, input logic [15:0] ticks);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_DEVICE_ADDRESS;
    cfg_data  <= {8'h00, addr};
    @(posedge clk_i);
    frames.write_reg(CFG_DEVICE_ADDRESS, {8'h00, addr});
    cfg_index <= CFG_PHASE_TICKS;
    cfg_data  <= ticks;
    @(posedge clk_i);
    frames.write_reg(CFG_PHASE_TICKS, ticks);
    cfg_we <= 1'b0;
  endtask

  task automatic run_random(input int count, input int idle, input int stall);
    send_idle_pct = idle;
    stall_pct     = stall;
    repeat (count) random_beat();
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: idle tick, full-scale payload, request while busy.
    send_beat(make_beat(ACT_TICK, 1'b1, 8'hFF));
    send_beat(make_beat(ACT_SEND, 1'b0, 8'hFF));
    send_beat(make_beat(ACT_SEND, 1'b1, 8'h00));
    send_beat(make_beat(ACT_TICK, 1'b0, 8'h00));
    settle();
    send_beat(make_beat(ACT_SEND, 1'b1, 8'h00));
    settle();
    // Zero-length phases run as one tick.
    write_regs(8'hFF, 16'h0000);
    send_beat(make_beat(ACT_SEND, 1'b0, 8'hA5));
    send_beat(make_beat(ACT_TICK, 1'b0, 8'h5A));
    settle();

    write_regs(8'h00, 16'd1);
    run_random(100, 0, 0);
    settle();

    write_regs(8'($urandom_range(255)), 16'd2);
    run_random(50, 59, 0);
    drain_results();
    run_random(50, 59, 0);
    settle();

    write_regs(8'($urandom_range(255)), 16'd1);
    run_random(100, 0, 59);
    settle();

    write_regs(8'($urandom_range(255)), 16'd3);
    run_random(100, 33, 33);
    settle();

    // Longest phases: the frame stays in START for the rest of the run.
    write_regs(8'($urandom_range(255)), 16'hFFFF);
    send_beat(make_beat(ACT_SEND, 1'($urandom_range(1)), 8'($urandom_range(255))));
    run_random(40, 0, 0);

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (frames.fail_count == 0 && frames.pending() == 0)
      $display("i2c_write_only_display_link regression: pass");
    else
      $display("i2c_write_only_display_link regression: fail");
    $finish;
  end

endmodule
